### sv/wca_pkg.sv
// wca_pkg: shared types, codes and constants for the window coverage accumulator.
// No dependencies; every other file of the block refers to it by scoped names.
package wca_pkg;

  // Field widths fixed by the interface
  localparam int DATA_W   = 32;
  localparam int SPAN_W   = 16;
  localparam int OFFSET_W = 12;
  localparam int OP_W     = 2;

  // Store depth: default and the largest supported value
  localparam int WINDOW_DEPTH_DEF = 4096;
  localparam int WINDOW_DEPTH_MAX = 1048576;

  // Command fields sized for the largest store
  localparam int CMD_ADDR_W = $clog2(WINDOW_DEPTH_MAX);
  localparam int CMD_CNT_W  = CMD_ADDR_W + 1;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [DATA_W-1:0] COUNT_MAX = '1;

  // Operation codes on the input channel
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes and reset values
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_START = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_END   = 1'd1;
  localparam logic [DATA_W-1:0] WINDOW_START_RST = 32'd0;
  localparam logic [DATA_W-1:0] WINDOW_END_RST   = 32'd4096;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_t;

  // One classified request as it travels through the queue
  typedef struct packed {
    cmd_kind_t             kind;
    logic [CMD_ADDR_W-1:0] addr;     // first window offset (add) or read offset
    logic [CMD_CNT_W-1:0]  cnt;      // positions to walk (add)
    logic                  oob;      // read offset beyond the store
    logic                  first;    // read at offset zero
  } cmd_t;

  typedef enum logic [2:0] {
    BS_INIT,
    BS_IDLE,
    BS_ADD,
    BS_CLEAR,
    BS_RD_PREV,
    BS_RD_CUR,
    BS_RD_DONE
  } back_state_t;

endpackage

### sv/wca_front.sv
// wca_front: accepts requests, holds the window registers and clips add intervals.
// Depends on wca_pkg; pushes classified commands into wca_fifo.
module wca_front #(
  parameter int WINDOW_DEPTH = wca_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [wca_pkg::OP_W-1:0]           in_operation,
  input  logic [wca_pkg::DATA_W-1:0]         in_align_start,
  input  logic [wca_pkg::SPAN_W-1:0]         in_ref_span,
  input  logic                               in_qc_fail,
  input  logic [wca_pkg::OFFSET_W-1:0]       in_read_offset,
  input  logic                               cfg_we,
  input  logic [wca_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wca_pkg::DATA_W-1:0]         cfg_wdata,
  input  logic                               init_busy,
  input  logic                               fifo_full,
  output logic                               push,
  output wca_pkg::cmd_t                      push_cmd
);

  localparam int DW = wca_pkg::DATA_W;
  localparam logic [DW:0] DEPTH_W = (DW+1)'(WINDOW_DEPTH);

  logic [DW-1:0] window_start_r;
  logic [DW-1:0] window_end_r;

  // stage A: captured request
  logic                        a_v_r;
  wca_pkg::cmd_kind_t          a_kind_r;
  logic [DW-1:0]               a_first_r;
  logic [DW:0]                 a_last_r;
  logic [DW:0]                 a_diff_r;
  logic [DW-1:0]               a_ws_r;
  logic [wca_pkg::OFFSET_W-1:0] a_off_r;

  // stage B: window length applied
  logic                        b_v_r;
  wca_pkg::cmd_kind_t          b_kind_r;
  logic [DW-1:0]               b_lo_r;
  logic [DW:0]                 b_last_r;
  logic [DW:0]                 b_wend_r;
  logic [DW-1:0]               b_ws_r;
  logic [wca_pkg::OFFSET_W-1:0] b_off_r;

  logic                        adv;
  logic                        in_acc;
  logic                        keep;
  wca_pkg::cmd_kind_t          kind_in;
  logic [DW:0]                 len;
  logic [DW:0]                 hi;
  logic                        hit;
  logic [DW-1:0]               start_off;
  logic [DW:0]                 cnt;

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_start_r <= wca_pkg::WINDOW_START_RST;
      window_end_r   <= wca_pkg::WINDOW_END_RST;
    end else if (cfg_we) begin
      if (cfg_index == wca_pkg::REG_WINDOW_START) window_start_r <= cfg_wdata;
      if (cfg_index == wca_pkg::REG_WINDOW_END)   window_end_r   <= cfg_wdata;
    end
  end

  // the whole front moves when the queue has room
  assign adv      = !fifo_full;
  assign in_ready = adv && !init_busy;
  assign in_acc   = in_valid && in_ready;

  // classify; failed adds and the unused code are dropped here
  always_comb begin
    kind_in = wca_pkg::CMD_ADD;
    keep    = 1'b0;
    unique case (in_operation)
      wca_pkg::OP_ADD: begin
        kind_in = wca_pkg::CMD_ADD;
        keep    = !in_qc_fail;
      end
      wca_pkg::OP_READ: begin
        kind_in = wca_pkg::CMD_READ;
        keep    = 1'b1;
      end
      wca_pkg::OP_CLEAR: begin
        kind_in = wca_pkg::CMD_CLEAR;
        keep    = 1'b1;
      end
      default: begin
        kind_in = wca_pkg::CMD_ADD;
        keep    = 1'b0;
      end
    endcase
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_acc && keep;
      b_v_r <= a_v_r;
    end
  end

  // stage A payload: interval end and raw window length
  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind_r  <= kind_in;
      a_first_r <= in_align_start;
      a_last_r  <= {1'b0, in_align_start} + (DW+1)'(in_ref_span);
      a_diff_r  <= {1'b0, window_end_r} - {1'b0, window_start_r};
      a_ws_r    <= window_start_r;
      a_off_r   <= in_read_offset;
    end
  end

  // window length: zero when empty, capped at the store depth
  always_comb begin
    if (a_diff_r[DW])          len = '0;
    else if (a_diff_r > DEPTH_W) len = DEPTH_W;
    else                       len = a_diff_r;
  end

  // stage B payload: window end and clipped interval start
  always_ff @(posedge clk) begin
    if (adv) begin
      b_kind_r <= a_kind_r;
      b_lo_r   <= (a_first_r < a_ws_r) ? a_ws_r : a_first_r;
      b_last_r <= a_last_r;
      b_wend_r <= {1'b0, a_ws_r} + len;
      b_ws_r   <= a_ws_r;
      b_off_r  <= a_off_r;
    end
  end

  // clip the end, drop intervals with nothing inside the window
  assign hi        = (b_last_r < b_wend_r) ? b_last_r : b_wend_r;
  assign hit       = ({1'b0, b_lo_r} < hi);
  assign start_off = b_lo_r - b_ws_r;
  assign cnt       = hi - {1'b0, b_lo_r};

  assign push = b_v_r && adv && ((b_kind_r != wca_pkg::CMD_ADD) || hit);

  always_comb begin
    push_cmd       = '0;
    push_cmd.kind  = b_kind_r;
    push_cmd.oob   = ((DW+1)'(b_off_r) >= DEPTH_W);
    push_cmd.first = (b_off_r == '0);
    if (b_kind_r == wca_pkg::CMD_ADD) begin
      push_cmd.addr = start_off[wca_pkg::CMD_ADDR_W-1:0];
      push_cmd.cnt  = cnt[wca_pkg::CMD_CNT_W-1:0];
    end else begin
      push_cmd.addr = wca_pkg::CMD_ADDR_W'(b_off_r);
    end
  end

endmodule

### sv/wca_fifo.sv
// wca_fifo: short command queue that decouples the front from the back.
// Depends on wca_pkg for the command type and queue depth.
module wca_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wca_pkg::cmd_t push_cmd,
  input  logic          pop,
  output wca_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  localparam int PW = wca_pkg::FIFO_PTR_W;

  wca_pkg::cmd_t   entry_r [wca_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW:0]     count_r;

  assign full  = (count_r == (PW+1)'(wca_pkg::FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

endmodule

### sv/wca_back.sv
// wca_back: depth store, add walk, read with step, clearing sweeps, output register.
// Depends on wca_pkg; takes commands from wca_fifo.
module wca_back #(
  parameter int WINDOW_DEPTH = wca_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wca_pkg::cmd_t              head,
  input  logic                       empty,
  output logic                       pop,
  output logic                       init_busy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [wca_pkg::DATA_W-1:0] out_depth,
  output logic [wca_pkg::DATA_W-1:0] out_abs_step
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int DW = wca_pkg::DATA_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

  wca_pkg::back_state_t state_r, state_nxt;

  logic [DW-1:0] mem [WINDOW_DEPTH];
  logic [DW-1:0] rdata_r;

  logic [AW-1:0] addr_r;
  logic [AW:0]   left_r;
  logic [AW-1:0] clr_r;
  logic          first_r;
  logic [DW-1:0] prev_r;
  logic          wb_v_r;
  logic [AW-1:0] wb_addr_r;
  logic          out_valid_r;
  logic [DW-1:0] out_depth_r;
  logic [DW-1:0] out_abs_step_r;

  // control decoded from the state
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          ld_cmd;
  logic          ld_prev;
  logic          ld_out;
  logic          ld_out_zero;
  logic          clr_step;
  logic          add_step;
  logic          head_ok;
  logic [DW-1:0] step;

  // a read may start only when the output slot is free
  assign head_ok = !empty &&
                   ((head.kind != wca_pkg::CMD_READ) || !out_valid_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wca_pkg::BS_INIT, wca_pkg::BS_CLEAR: begin
        if (clr_r == LAST_ADDR) state_nxt = wca_pkg::BS_IDLE;
      end
      wca_pkg::BS_IDLE: begin
        if (head_ok) begin
          unique case (head.kind)
            wca_pkg::CMD_ADD:   state_nxt = wca_pkg::BS_ADD;
            wca_pkg::CMD_CLEAR: state_nxt = wca_pkg::BS_CLEAR;
            wca_pkg::CMD_READ:  state_nxt = head.oob ? wca_pkg::BS_IDLE : wca_pkg::BS_RD_PREV;
          endcase
        end
      end
      wca_pkg::BS_ADD: begin
        if (left_r == (AW+1)'(1)) state_nxt = wca_pkg::BS_IDLE;
      end
      wca_pkg::BS_RD_PREV: state_nxt = wca_pkg::BS_RD_CUR;
      wca_pkg::BS_RD_CUR:  state_nxt = wca_pkg::BS_RD_DONE;
      wca_pkg::BS_RD_DONE: state_nxt = wca_pkg::BS_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop         = 1'b0;
    ld_cmd      = 1'b0;
    ld_prev     = 1'b0;
    ld_out      = 1'b0;
    ld_out_zero = 1'b0;
    clr_step    = 1'b0;
    add_step    = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = addr_r;
    unique case (state_r)
      wca_pkg::BS_INIT, wca_pkg::BS_CLEAR: clr_step = 1'b1;
      wca_pkg::BS_IDLE: begin
        if (head_ok) begin
          pop    = 1'b1;
          ld_cmd = 1'b1;
          ld_out_zero = (head.kind == wca_pkg::CMD_READ) && head.oob;
        end
      end
      wca_pkg::BS_ADD: begin
        mem_re   = 1'b1;
        add_step = 1'b1;
      end
      wca_pkg::BS_RD_PREV: begin
        mem_re    = 1'b1;
        mem_raddr = addr_r - 1'b1;
      end
      wca_pkg::BS_RD_CUR: begin
        mem_re  = 1'b1;
        ld_prev = 1'b1;
      end
      wca_pkg::BS_RD_DONE: ld_out = 1'b1;
    endcase
  end

  // sweeps write zero; otherwise the add walk writes back one step behind its read
  always_comb begin
    if (clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = wb_v_r;
      mem_waddr = wb_addr_r;
      mem_wdata = (rdata_r == wca_pkg::COUNT_MAX) ? rdata_r : rdata_r + 1'b1;
    end
  end

  // depth store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wca_pkg::BS_INIT;
      clr_r       <= '0;
      wb_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wb_v_r  <= add_step;
      if (clr_step) clr_r <= (clr_r == LAST_ADDR) ? '0 : clr_r + 1'b1;
      if (ld_out || ld_out_zero) out_valid_r <= 1'b1;
      else if (out_ready)        out_valid_r <= 1'b0;
    end
  end

  // walk counters and read operands
  always_ff @(posedge clk) begin
    wb_addr_r <= addr_r;
    if (ld_cmd) begin
      addr_r  <= head.addr[AW-1:0];
      left_r  <= head.cnt[AW:0];
      first_r <= head.first;
    end else if (add_step) begin
      addr_r <= addr_r + 1'b1;
      left_r <= left_r - 1'b1;
    end
    if (ld_prev) prev_r <= rdata_r;
  end

  // absolute step against the previous offset
  assign step = first_r ? '0 :
                (rdata_r >= prev_r) ? rdata_r - prev_r : prev_r - rdata_r;

  // output register
  always_ff @(posedge clk) begin
    if (ld_out_zero) begin
      out_depth_r    <= '0;
      out_abs_step_r <= '0;
    end else if (ld_out) begin
      out_depth_r    <= rdata_r;
      out_abs_step_r <= step;
    end
  end

  assign init_busy    = (state_r == wca_pkg::BS_INIT);
  assign out_valid    = out_valid_r;
  assign out_depth    = out_depth_r;
  assign out_abs_step = out_abs_step_r;

endmodule

### sv/window_coverage_accumulator_top.sv
// window_coverage_accumulator_top: per-position read-depth pileup over a reference window.
// Depends on wca_pkg, wca_front, wca_fifo and wca_back.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   operation, align_start, ref_span, qc_fail, read_offset
//   out      out_valid / out_ready depth, abs_step
//   cfg      cfg_we                cfg_index, cfg_wdata
//
// Front: one request in each stage; it stalls only when the queue is full. Back: an add
// does one store read-modify-write per covered position, a read fetches the previous
// and the current entry, and a clear writes zero to every entry of the store.
// After reset a clearing pass zeroes the store; in_ready is low.
// A read waits in the queue while the output register still holds an untaken result.
module window_coverage_accumulator_top #(
  parameter int WINDOW_DEPTH = wca_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wca_pkg::OP_W-1:0]        in_operation,
  input  logic [wca_pkg::DATA_W-1:0]      in_align_start,
  input  logic [wca_pkg::SPAN_W-1:0]      in_ref_span,
  input  logic                            in_qc_fail,
  input  logic [wca_pkg::OFFSET_W-1:0]    in_read_offset,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [wca_pkg::DATA_W-1:0]      out_depth,
  output logic [wca_pkg::DATA_W-1:0]      out_abs_step,
  input  logic                            cfg_we,
  input  logic [wca_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wca_pkg::DATA_W-1:0]      cfg_wdata
);

  logic          init_busy;
  logic          fifo_full;
  logic          fifo_empty;
  logic          push;
  logic          pop;
  wca_pkg::cmd_t push_cmd;
  wca_pkg::cmd_t head;

  // request intake and interval clipping
  wca_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_align_start (in_align_start),
    .in_ref_span    (in_ref_span),
    .in_qc_fail     (in_qc_fail),
    .in_read_offset (in_read_offset),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .init_busy      (init_busy),
    .fifo_full      (fifo_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  // command queue
  wca_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  // store and execution
  wca_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .empty        (fifo_empty),
    .pop          (pop),
    .init_busy    (init_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_depth    (out_depth),
    .out_abs_step (out_abs_step)
  );

endmodule

### verif/testbench.sv
// testbench: self-checking bench for window_coverage_accumulator_top, with directed and random tests.
// It keeps its own depth store and checks every read result against it.
// Depends on wca_pkg and window_coverage_accumulator_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [wca_pkg::DATA_W-1:0]      data_t;
  typedef logic [wca_pkg::OP_W-1:0]        op_t;
  typedef logic [wca_pkg::SPAN_W-1:0]      span_t;
  typedef logic [wca_pkg::OFFSET_W-1:0]    offset_t;
  typedef logic [wca_pkg::CFG_INDEX_W-1:0] cfg_index_t;

  localparam int STORE_DEPTH = wca_pkg::WINDOW_DEPTH_DEF;
  localparam op_t OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  // Watchdog bound; it covers every request at worst, even a full-window add or a clear
  localparam longint CYCLE_LIMIT = 12_000_000;

  typedef struct {
    data_t depth;
    data_t abs_step;
  } depth_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  op_t        in_operation = wca_pkg::OP_ADD;
  data_t      in_align_start = '0;
  span_t      in_ref_span = '0;
  logic       in_qc_fail = 1'b0;
  offset_t    in_read_offset = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  data_t      out_depth;
  data_t      out_abs_step;
  logic       cfg_we = 1'b0;
  cfg_index_t cfg_index = wca_pkg::REG_WINDOW_START;
  data_t      cfg_wdata = '0;

  // Predicted block state
  data_t         depth_model [STORE_DEPTH];
  data_t         win_first = wca_pkg::WINDOW_START_RST;
  data_t         win_limit = wca_pkg::WINDOW_END_RST;
  depth_result_t depth_results [$];

  int     error_count = 0;
  int     sent_requests = 0;
  int     burst_left = 0;
  longint cycle_count = 0;
  int     stall_left = 0;
  int     rx_mode = 0;
  int     rx_mode_left = 0;

  window_coverage_accumulator_top #(.WINDOW_DEPTH(STORE_DEPTH)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    foreach (depth_model[i]) depth_model[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Effective window length, cut to the store depth; zero when empty
  function automatic longint unsigned window_length();
    longint unsigned len;
    if (win_limit <= win_first) return 0;
    len = win_limit - win_first;
    return (len > STORE_DEPTH) ? STORE_DEPTH : len;
  endfunction

  // Clip [first, first + span) to the window and bump each covered count
  function automatic void pileup_add(input data_t first, input span_t span);
    longint unsigned base, len, lo, hi, last, pos;
    len = window_length();
    if (len == 0 || span == 0) return;
    base = win_first;
    last = first;
    last += span;
    lo = (first < base) ? base : first;
    hi = (last > base + len) ? base + len : last;
    if (lo >= hi) return;
    for (pos = lo - base; pos < hi - base; pos++) begin
      if (depth_model[pos] != wca_pkg::COUNT_MAX) depth_model[pos]++;
    end
  endfunction

  // Present one request, wait for acceptance, then update the prediction
  task automatic send_request(input op_t op, input data_t start, input span_t span,
                              input logic qc, input offset_t offset);
    depth_result_t want;
    data_t prev;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_align_start <= start;
    in_ref_span    <= span;
    in_qc_fail     <= qc;
    in_read_offset <= offset;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    unique case (op)
      wca_pkg::OP_ADD: begin
        if (!qc) pileup_add(start, span);
      end
      wca_pkg::OP_READ: begin
        want.depth = '0;
        want.abs_step = '0;
        if (offset < STORE_DEPTH) begin
          want.depth = depth_model[offset];
          if (offset != 0) begin
            prev = depth_model[offset - 1];
            want.abs_step = (want.depth >= prev) ? want.depth - prev : prev - want.depth;
          end
        end
        depth_results.push_back(want);
      end
      wca_pkg::OP_CLEAR: begin
        foreach (depth_model[i]) depth_model[i] = '0;
      end
      default: ;
    endcase
    sent_requests++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic settle_block();
    @(negedge clk) in_valid <= 1'b0;
    while (depth_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A read queues behind all earlier work, so its result marks the block idle
  task automatic quiesce();
    send_request(wca_pkg::OP_READ, $urandom, span_t'($urandom), 1'($urandom),
                 offset_t'($urandom));
    settle_block();
  endtask

  task automatic write_window(input data_t first, input data_t limit);
    quiesce();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= wca_pkg::REG_WINDOW_START;
    cfg_wdata <= first;
    @(negedge clk);
    cfg_index <= wca_pkg::REG_WINDOW_END;
    cfg_wdata <= limit;
    @(negedge clk) cfg_we <= 1'b0;
    win_first = first;
    win_limit = limit;
  endtask

  // Sender bursts: random length, random gap between them
  task automatic pace_sender();
    if (burst_left == 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Receiver stalls: modes of no stalls, short frequent stalls, long stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      unique case (rx_mode)
        1: if ($urandom_range(0, 99) < 30) stall_left = $urandom_range(1, 3);
        2: if ($urandom_range(0, 99) < 10) stall_left = $urandom_range(5, 40);
        default: ;
      endcase
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(50, 400);
    end else begin
      rx_mode_left--;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    depth_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (depth_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got depth %0d abs_step %0d",
                 $time, out_depth, out_abs_step);
        error_count++;
      end else begin
        want = depth_results.pop_front();
        if (out_depth !== want.depth) begin
          $display("%0t: depth mismatch, expected %0d, got %0d", $time, want.depth, out_depth);
          error_count++;
        end
        if (out_abs_step !== want.abs_step) begin
          $display("%0t: abs_step mismatch, expected %0d, got %0d",
                   $time, want.abs_step, out_abs_step);
          error_count++;
        end
      end
    end
  end

  // Store comes out of reset empty
  task automatic test_reset_state();
    send_request(wca_pkg::OP_READ, '0, '0, 1'b0, 12'd0);
    send_request(wca_pkg::OP_READ, '1, '1, 1'b1, 12'd1);
    send_request(wca_pkg::OP_READ, '0, '0, 1'b0, 12'hFFF);
  endtask

  // Overlapping adds, skipped adds, reads, unused code and clear on the reset window
  task automatic test_pileup_basic();
    send_request(wca_pkg::OP_ADD, 32'd0, 16'd10, 1'b0, 12'd0);
    send_request(wca_pkg::OP_ADD, 32'd5, 16'd10, 1'b0, 12'd0);
    send_request(wca_pkg::OP_ADD, 32'd3, 16'd4, 1'b1, 12'd0);           // failed QC
    send_request(wca_pkg::OP_ADD, 32'd7, 16'd0, 1'b0, 12'd0);           // zero span
    send_request(wca_pkg::OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 12'd0); // far past the window
    send_request(wca_pkg::OP_ADD, 32'd4090, 16'hFFFF, 1'b0, 12'd0);     // runs off the end
    send_request(wca_pkg::OP_READ, '0, '0, 1'b0, 12'd0);
    send_request(wca_pkg::OP_READ, '0, '0, 1'b0, 12'd5);
    send_request(wca_pkg::OP_READ, '0, '0, 1'b0, 12'd10);
    send_request(wca_pkg::OP_READ, '0, '0, 1'b0, 12'd15);
    send_request(wca_pkg::OP_READ, '0, '0, 1'b0, 12'hFFF);
    send_request(OP_UNUSED, 32'd0, 16'd100, 1'b0, 12'd5);
    send_request(wca_pkg::OP_READ, '0, '0, 1'b0, 12'd5);
    send_request(wca_pkg::OP_CLEAR, '1, '1, 1'b1, '1);
    send_request(wca_pkg::OP_READ, '0, '0, 1'b0, 12'd5);
  endtask

  // Window at the top of the address space, long window, empty windows
  task automatic test_window_limits();
    write_window(32'hFFFF_F000, 32'hFFFF_FFFF);
    send_request(wca_pkg::OP_ADD, 32'hFFFF_FFF0, 16'hFFFF, 1'b0, 12'd0);
    send_request(wca_pkg::OP_ADD, 32'd0, 16'hFFFF, 1'b0, 12'd0);    // below the window
    send_request(wca_pkg::OP_READ, '0, '0, 1'b0, 12'd4094);
    send_request(wca_pkg::OP_READ, '0, '0, 1'b0, 12'd4095);         // beyond window length
    write_window(32'd0, 32'hFFFF_FFFF);
    send_request(wca_pkg::OP_ADD, 32'd4000, 16'hFFFF, 1'b0, 12'd0);
    send_request(wca_pkg::OP_READ, '0, '0, 1'b0, 12'd4095);
    write_window(32'd100, 32'd100);
    send_request(wca_pkg::OP_ADD, 32'd0, 16'hFFFF, 1'b0, 12'd0);
    write_window(32'hFFFF_FFFF, 32'd0);
    send_request(wca_pkg::OP_ADD, 32'hFFFF_FFFF, 16'd1, 1'b0, 12'd0);
    send_request(wca_pkg::OP_READ, '0, '0, 1'b0, 12'd100);
  endtask

  // Random traffic over a series of windows; most adds land near the window
  task automatic test_random_traffic();
    data_t           first, limit, start;
    span_t           span;
    offset_t         offset;
    longint unsigned len;
    int              quota, target, pick, pick_span;
    for (int phase = 0; phase < 9; phase++) begin
      quota = 90;
      unique case (phase)
        0: begin first = 32'd0; limit = 32'd4096; end
        1: begin first = 32'd1000; limit = 32'd1600; end
        2: begin first = 32'd0; limit = 32'hFFFF_FFFF; end
        3: begin first = 32'hFFFF_F000; limit = 32'hFFFF_FFFF; end
        4: begin first = 32'h8000_0000; limit = 32'h8000_0010; quota = 70; end
        5: begin first = $urandom; limit = first + $urandom_range(1, 6000); end
        6: begin first = $urandom; limit = $urandom; quota = 40; end
        7: begin first = 32'd500; limit = 32'd200; quota = 40; end
        default: begin first = 32'd0; limit = 32'd4096; quota = 60; end
      endcase
      write_window(first, limit);
      len = window_length();
      target = sent_requests + quota;
      while (sent_requests < target) begin
        pace_sender();
        if ($urandom_range(0, 99) < 2) settle_block();
        pick = $urandom_range(0, 99);
        pick_span = $urandom_range(0, 99);
        if (pick_span < 4) span = '0;
        else if (pick_span < 12) span = span_t'($urandom_range(0, 65535));
        else span = span_t'($urandom_range(1, 200));
        if (len > 0 && $urandom_range(0, 4) != 0)
          offset = offset_t'($urandom_range(0, int'(len) - 1));
        else
          offset = offset_t'($urandom);
        start = win_first + data_t'($urandom_range(0, int'(len) + 300)) - 32'd150;
        if (pick < 55)
          send_request(wca_pkg::OP_ADD, start, span, $urandom_range(0, 9) == 0,
                       offset_t'($urandom));
        else if (pick < 62)
          send_request(wca_pkg::OP_ADD, $urandom, span_t'($urandom), 1'($urandom),
                       offset_t'($urandom));
        else if (pick < 95)
          send_request(wca_pkg::OP_READ, $urandom, span_t'($urandom), 1'($urandom), offset);
        else if (pick < 97)
          send_request(wca_pkg::OP_CLEAR, $urandom, span_t'($urandom), 1'($urandom),
                       offset_t'($urandom));
        else
          send_request(OP_UNUSED, $urandom, span_t'($urandom), 1'($urandom),
                       offset_t'($urandom));
      end
    end
  endtask

  initial begin
    @(posedge rst_n);
    test_reset_state();
    test_pileup_basic();
    test_window_limits();
    test_random_traffic();
    quiesce();
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
